// File: src/mlfq_pkg.sv
// Shared types and constants of the thread scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

	localparam int TID_W = 6;
	localparam int PERIOD_W = 16;
	localparam int SWITCH_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AGING_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_THREAD = 2'd2;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_TICK   = 3'd1,
		OP_YIELD  = 3'd2,
		OP_BLOCK  = 3'd3,
		OP_EXIT   = 3'd4,
		OP_WAKE   = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ABSENT  = 2'd0,
		ST_READY   = 2'd1,
		ST_RUNNING = 2'd2,
		ST_BLOCKED = 2'd3
	} thr_state_t;

	typedef enum logic [1:0] {
		GO_PREEMPT = 2'd0,
		GO_YIELD   = 2'd1,
		GO_BLOCK   = 2'd2,
		GO_NONE    = 2'd3
	} go_kind_t;

	// Command broadcast to every cell of the ready list.
	typedef enum logic [2:0] {
		C_NOP = 3'd0,
		C_INS = 3'd1,
		C_REM = 3'd2,
		C_ROT = 3'd3,
		C_AGE = 3'd4
	} cell_op_t;

endpackage

// File: src/mlfq_cell.sv
// One slot of the ready list: holds a queued thread and trades it with its neighbors.
`timescale 1ns / 1ps
module mlfq_cell #(
	parameter int IDX = 0,
	parameter int NCELL = 64,
	parameter int IDXW = 6,
	parameter int LVW = 2,
	parameter int RUNW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mlfq_pkg::cell_op_t         cmd_op,
	input  logic [LVW-1:0]             cmd_lvl,
	input  logic [mlfq_pkg::TID_W-1:0] cmd_id,
	input  logic [RUNW-1:0]            cmd_runs,
	input  logic [IDXW-1:0]            cmd_pos,
	input  logic                       lf_vld,
	input  logic [mlfq_pkg::TID_W-1:0] lf_id,
	input  logic [LVW-1:0]             lf_lvl,
	input  logic [RUNW-1:0]            lf_runs,
	input  logic                       lf_cond,
	input  logic                       rt_vld,
	input  logic [mlfq_pkg::TID_W-1:0] rt_id,
	input  logic [LVW-1:0]             rt_lvl,
	input  logic [RUNW-1:0]            rt_runs,
	output logic                       vld,
	output logic [mlfq_pkg::TID_W-1:0] id,
	output logic [LVW-1:0]             lvl,
	output logic [RUNW-1:0]            runs,
	output logic                       cond
);
	import mlfq_pkg::*;

	logic                 vld_q;
	logic [TID_W-1:0]     id_q;
	logic [LVW-1:0]       lvl_q;
	logic [RUNW-1:0]      runs_q;
	logic                 at_or_after;

	// The list is kept sorted by level, so the insert point is where cond first rises.
	assign cond = !vld_q || (lvl_q > cmd_lvl);
	assign at_or_after = (IDXW'(IDX) >= cmd_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (cmd_op)
				C_INS: begin
					if (lf_cond) begin
						vld_q <= lf_vld;
					end else if (cond) begin
						vld_q <= 1'b1;
					end
				end
				C_REM: begin
					if (at_or_after) begin
						vld_q <= (IDX == NCELL - 1) ? 1'b0 : rt_vld;
					end
				end
				C_ROT: begin
					vld_q <= rt_vld;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd_op)
			C_INS: begin
				if (lf_cond) begin
					id_q <= lf_id;
					lvl_q <= lf_lvl;
					runs_q <= lf_runs;
				end else if (cond) begin
					id_q <= cmd_id;
					lvl_q <= cmd_lvl;
					runs_q <= cmd_runs;
				end
			end
			C_REM: begin
				if (at_or_after) begin
					id_q <= rt_id;
					lvl_q <= rt_lvl;
					runs_q <= rt_runs;
				end
			end
			C_ROT: begin
				id_q <= rt_id;
				lvl_q <= rt_lvl;
				runs_q <= rt_runs;
			end
			C_AGE: begin
				lvl_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign vld = vld_q;
	assign id = id_q;
	assign lvl = lvl_q;
	assign runs = runs_q;

endmodule

// File: src/mlfq_psjf_thread_scheduler_top.sv
// Top level of the MLFQ / PSJF thread scheduler: event sequencer, thread table, ready list.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    opcode, thread_id, has_waiter
// out       out  out_valid / out_stall  running_id, running_valid, switch_total, status_code
// cfg       in   cfg_wr_en              cfg_index, cfg_data
//
// Steps: create, wake and rejected events pass through S_INST, S_RD, S_EXEC and S_OUT.
// A scheduler pass adds S_OUTGO, S_AGE and S_TAKE; in PSJF mode S_SCAN comes before
// S_TAKE and rotates the ready list once through all its MAX_THREADS (capped at 64)
// cells to find the least run count; exit with a waiter adds S_WAITER.
// Reset clears control state, the thread table valid bits and the ready list at once.
// A result waits in the output register under out_stall; the next event is accepted
// meanwhile and holds in its final step until the register frees.
module mlfq_psjf_thread_scheduler_top #(
	parameter int NUM_LEVELS = 4,
	parameter int MAX_THREADS = 64,
	parameter int RUN_COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mlfq_pkg::PERIOD_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          opcode,
	input  logic [mlfq_pkg::TID_W-1:0]          thread_id,
	input  logic                                has_waiter,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mlfq_pkg::TID_W-1:0]          running_id,
	output logic                                running_valid,
	output logic [mlfq_pkg::SWITCH_W-1:0]       switch_total,
	output logic                                status_code
);
	import mlfq_pkg::*;

	// Ids are six bits wide, so no more than 64 threads can ever be live.
	localparam int NCELL = (MAX_THREADS < 64) ? MAX_THREADS : 64;
	localparam int IDXW = $clog2(NCELL);
	localparam int LVW = $clog2(NUM_LEVELS);
	localparam int RUNW = RUN_COUNT_BITS;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_INST   = 10'b0000000010,
		S_RD     = 10'b0000000100,
		S_EXEC   = 10'b0000001000,
		S_WAITER = 10'b0000010000,
		S_OUTGO  = 10'b0000100000,
		S_AGE    = 10'b0001000000,
		S_SCAN   = 10'b0010000000,
		S_TAKE   = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} fsm_t;

	fsm_t                 state_q;

	// configuration
	logic                 mode_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [TID_W-1:0]     main_q;

	// latched event
	logic [2:0]           op_q;
	logic [TID_W-1:0]     tid_q;
	logic                 wt_q;

	// scheduler state
	logic                 started_q;
	logic [TID_W-1:0]     cur_q;
	logic                 cur_v_q;
	logic [LVW-1:0]       cur_lvl_q;
	logic [RUNW-1:0]      cur_runs_q;
	logic [PERIOD_W-1:0]  phase_q;
	logic [SWITCH_W-1:0]  sw_q;
	go_kind_t             kind_q;
	logic                 rej_q;

	// thread table: state and run count, with a valid bit per entry
	thr_state_t           mem_st [NCELL];
	logic [RUNW-1:0]      mem_runs [NCELL];
	logic [NCELL-1:0]     tvld_q;
	thr_state_t           rd_st_q;
	logic [RUNW-1:0]      rd_runs_q;
	logic                 rdv_q;

	// pick search
	logic [IDXW-1:0]      scan_q;
	logic [IDXW-1:0]      pos_q;
	logic                 found_q;
	logic [TID_W-1:0]     best_id_q;
	logic [LVW-1:0]       best_lvl_q;
	logic [RUNW-1:0]      best_runs_q;

	// output register
	logic                 out_valid_q;
	logic [TID_W-1:0]     out_id_q;
	logic                 out_rv_q;
	logic [SWITCH_W-1:0]  out_sw_q;
	logic                 out_rej_q;

	// ready list cells
	logic                 c_vld  [NCELL];
	logic [TID_W-1:0]     c_id   [NCELL];
	logic [LVW-1:0]       c_lvl  [NCELL];
	logic [RUNW-1:0]      c_runs [NCELL];
	logic                 c_cond [NCELL];
	logic [NCELL-1:0]     vld_vec;

	// cell command and table write
	cell_op_t             c_op;
	logic [LVW-1:0]       c_lvl_in;
	logic [TID_W-1:0]     c_id_in;
	logic [RUNW-1:0]      c_runs_in;
	logic [IDXW-1:0]      c_pos_in;
	logic                 mem_we;
	logic [TID_W-1:0]     mem_wa;
	thr_state_t           mem_wst;
	logic [RUNW-1:0]      mem_wr;

	// decode helpers
	thr_state_t           t_st;
	logic [RUNW-1:0]      t_runs;
	logic                 tid_ok;
	logic                 main_ok;
	logic                 cr_ok;
	logic                 wk_ok;
	logic                 ex_ok;
	logic [RUNW-1:0]      runs_inc;
	logic [LVW-1:0]       out_lvl;
	logic [PERIOD_W:0]    phase_nxt;
	logic [PERIOD_W:0]    period_eff;
	logic [SWITCH_W-1:0]  sw_inc;
	logic                 pick_found;
	logic [TID_W-1:0]     pick_id;
	logic [LVW-1:0]       pick_lvl;
	logic [RUNW-1:0]      pick_runs;
	logic                 out_load;
	logic                 ex_rej;
	fsm_t                 ex_next;
	go_kind_t             ex_kind;

	assign in_stall = (state_q != S_IDLE);

	assign t_st = rdv_q ? rd_st_q : ST_ABSENT;
	assign t_runs = rdv_q ? rd_runs_q : '0;
	assign tid_ok = (32'(tid_q) < MAX_THREADS);
	assign main_ok = (32'(main_q) < MAX_THREADS);
	assign cr_ok = tid_ok && (t_st == ST_ABSENT);
	assign wk_ok = tid_ok && (t_st == ST_BLOCKED);
	assign ex_ok = cur_v_q && (!wt_q || wk_ok);

	// Saturate the run count; in MLFQ mode a preempted thread drops a level, down to the lowest.
	assign runs_inc = (&cur_runs_q) ? cur_runs_q : cur_runs_q + RUNW'(1);
	always_comb begin
		out_lvl = '0;
		if (mode_q) begin
			out_lvl = cur_lvl_q;
			if ((kind_q == GO_PREEMPT) && (32'(cur_lvl_q) < NUM_LEVELS - 1)) begin
				out_lvl = cur_lvl_q + LVW'(1);
			end
		end
	end

	assign period_eff = (period_q == '0) ? (PERIOD_W+1)'(1) : {1'b0, period_q};
	assign phase_nxt = {1'b0, phase_q} + (PERIOD_W+1)'(1);
	assign sw_inc = (&sw_q) ? sw_q : sw_q + SWITCH_W'(1);

	// MLFQ takes the list head; PSJF takes what the rotation found.
	assign pick_found = mode_q ? c_vld[0] : found_q;
	assign pick_id = mode_q ? c_id[0] : best_id_q;
	assign pick_lvl = mode_q ? c_lvl[0] : best_lvl_q;
	assign pick_runs = mode_q ? c_runs[0] : best_runs_q;

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Outcome of the latched event in the execute step: reject flag, next step, pass kind.
	always_comb begin
		ex_rej = 1'b0;
		ex_next = S_OUT;
		ex_kind = GO_NONE;
		case (op_q)
			OP_CREATE: begin
				ex_rej = !cr_ok;
			end
			OP_TICK: begin
				if (cur_v_q) begin
					ex_kind = GO_PREEMPT;
					ex_next = S_OUTGO;
				end else if (c_vld[0]) begin
					ex_next = S_OUTGO;
				end
			end
			OP_YIELD, OP_BLOCK: begin
				if (!cur_v_q) begin
					ex_rej = 1'b1;
				end else begin
					ex_kind = (op_q == OP_YIELD) ? GO_YIELD : GO_BLOCK;
					ex_next = S_OUTGO;
				end
			end
			OP_EXIT: begin
				if (!ex_ok) begin
					ex_rej = 1'b1;
				end else begin
					ex_next = wt_q ? S_WAITER : S_OUTGO;
				end
			end
			OP_WAKE: begin
				ex_rej = !wk_ok;
			end
			default: begin
				ex_rej = 1'b1;
			end
		endcase
	end

	always_comb begin
		c_op = C_NOP;
		c_lvl_in = '0;
		c_id_in = tid_q;
		c_runs_in = '0;
		c_pos_in = pos_q;
		mem_we = 1'b0;
		mem_wa = cur_q;
		mem_wst = ST_READY;
		mem_wr = '0;
		case (state_q)
			S_INST: begin
				if ((op_q == OP_CREATE) && !started_q && main_ok) begin
					mem_we = 1'b1;
					mem_wa = main_q;
					mem_wst = ST_RUNNING;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_CREATE: begin
						if (cr_ok) begin
							mem_we = 1'b1;
							mem_wa = tid_q;
							c_op = C_INS;
						end
					end
					OP_WAKE: begin
						if (wk_ok) begin
							mem_we = 1'b1;
							mem_wa = tid_q;
							mem_wr = t_runs;
							c_op = C_INS;
							c_runs_in = t_runs;
						end
					end
					OP_EXIT: begin
						if (ex_ok) begin
							mem_we = 1'b1;
							mem_wst = ST_ABSENT;
						end
					end
					default: begin
					end
				endcase
			end
			S_WAITER: begin
				mem_we = 1'b1;
				mem_wa = tid_q;
				mem_wr = t_runs;
				c_op = C_INS;
				c_runs_in = t_runs;
			end
			S_OUTGO: begin
				if (cur_v_q && (kind_q != GO_NONE)) begin
					mem_we = 1'b1;
					mem_wr = runs_inc;
					if (kind_q == GO_BLOCK) begin
						mem_wst = ST_BLOCKED;
					end else begin
						c_op = C_INS;
						c_lvl_in = out_lvl;
						c_id_in = cur_q;
						c_runs_in = runs_inc;
					end
				end
			end
			S_AGE: begin
				if (mode_q && (phase_q == '0)) begin
					c_op = C_AGE;
				end
			end
			S_SCAN: begin
				c_op = C_ROT;
			end
			S_TAKE: begin
				if (pick_found) begin
					mem_we = 1'b1;
					mem_wa = pick_id;
					mem_wst = ST_RUNNING;
					mem_wr = pick_runs;
					c_op = C_REM;
				end
			end
			default: begin
			end
		endcase
	end

	// thread table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_st[mem_wa[IDXW-1:0]] <= mem_wst;
			mem_runs[mem_wa[IDXW-1:0]] <= mem_wr;
		end
		if (state_q == S_RD) begin
			rd_st_q <= mem_st[tid_q[IDXW-1:0]];
			rd_runs_q <= mem_runs[tid_q[IDXW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (mem_we) begin
				tvld_q[mem_wa[IDXW-1:0]] <= 1'b1;
			end
			if (state_q == S_RD) begin
				rdv_q <= tvld_q[tid_q[IDXW-1:0]];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			period_q <= PERIOD_W'(100);
			main_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_POLICY_MODE:  mode_q <= cfg_data[0];
				CFG_AGING_PERIOD: period_q <= cfg_data;
				CFG_MAIN_THREAD:  main_q <= cfg_data[TID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// event sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
			cur_q <= '0;
			cur_v_q <= 1'b0;
			cur_lvl_q <= '0;
			cur_runs_q <= '0;
			phase_q <= '0;
			sw_q <= '0;
			kind_q <= GO_NONE;
			rej_q <= 1'b0;
			scan_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result beat, or drop the one the receiver just took.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_INST;
					end
				end
				S_INST: begin
					// The first create puts the main thread on the core.
					if ((op_q == OP_CREATE) && !started_q) begin
						started_q <= 1'b1;
						if (main_ok) begin
							cur_q <= main_q;
							cur_v_q <= 1'b1;
							cur_lvl_q <= '0;
							cur_runs_q <= '0;
						end
					end
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					rej_q <= ex_rej;
					kind_q <= ex_kind;
					state_q <= ex_next;
					if (op_q == OP_TICK) begin
						phase_q <= (phase_nxt >= period_eff) ? '0 : phase_nxt[PERIOD_W-1:0];
					end
					if ((op_q == OP_EXIT) && ex_ok) begin
						cur_v_q <= 1'b0;
					end
				end
				S_WAITER: begin
					state_q <= S_OUTGO;
				end
				S_OUTGO: begin
					sw_q <= sw_inc;
					cur_v_q <= 1'b0;
					state_q <= S_AGE;
				end
				S_AGE: begin
					pos_q <= '0;
					found_q <= 1'b0;
					scan_q <= '0;
					state_q <= mode_q ? S_TAKE : S_SCAN;
				end
				S_SCAN: begin
					// Cell 0 shows list entry scan_q; strict less keeps the first on ties.
					if (c_vld[0] && (!found_q || (c_runs[0] < best_runs_q))) begin
						found_q <= 1'b1;
						pos_q <= scan_q;
					end
					scan_q <= scan_q + IDXW'(1);
					if (scan_q == IDXW'(NCELL - 1)) begin
						state_q <= S_TAKE;
					end
				end
				S_TAKE: begin
					if (pick_found) begin
						cur_q <= pick_id;
						cur_v_q <= 1'b1;
						cur_lvl_q <= pick_lvl;
						cur_runs_q <= pick_runs;
						sw_q <= sw_inc;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			op_q <= opcode;
			tid_q <= thread_id;
			wt_q <= has_waiter;
		end
		if ((state_q == S_SCAN) && c_vld[0] && (!found_q || (c_runs[0] < best_runs_q))) begin
			best_id_q <= c_id[0];
			best_lvl_q <= c_lvl[0];
			best_runs_q <= c_runs[0];
		end
		if (out_load) begin
			out_id_q <= cur_v_q ? cur_q : '0;
			out_rv_q <= cur_v_q;
			out_sw_q <= sw_q;
			out_rej_q <= rej_q;
		end
	end

	// ready list: sorted by level, FIFO within a level; ring-wired for the scan
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic             lf_vld;
		logic [TID_W-1:0] lf_id;
		logic [LVW-1:0]   lf_lvl;
		logic [RUNW-1:0]  lf_runs;
		logic             lf_cond;
		logic             rt_vld;
		logic [TID_W-1:0] rt_id;
		logic [LVW-1:0]   rt_lvl;
		logic [RUNW-1:0]  rt_runs;

		if (i == 0) begin : g_first
			assign lf_vld = 1'b0;
			assign lf_id = '0;
			assign lf_lvl = '0;
			assign lf_runs = '0;
			assign lf_cond = 1'b0;
		end else begin : g_mid
			assign lf_vld = c_vld[i-1];
			assign lf_id = c_id[i-1];
			assign lf_lvl = c_lvl[i-1];
			assign lf_runs = c_runs[i-1];
			assign lf_cond = c_cond[i-1];
		end

		if (i == NCELL - 1) begin : g_last
			assign rt_vld = c_vld[0];
			assign rt_id = c_id[0];
			assign rt_lvl = c_lvl[0];
			assign rt_runs = c_runs[0];
		end else begin : g_inner
			assign rt_vld = c_vld[i+1];
			assign rt_id = c_id[i+1];
			assign rt_lvl = c_lvl[i+1];
			assign rt_runs = c_runs[i+1];
		end

		mlfq_cell #(
			.IDX   (i),
			.NCELL (NCELL),
			.IDXW  (IDXW),
			.LVW   (LVW),
			.RUNW  (RUNW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd_op   (c_op),
			.cmd_lvl  (c_lvl_in),
			.cmd_id   (c_id_in),
			.cmd_runs (c_runs_in),
			.cmd_pos  (c_pos_in),
			.lf_vld   (lf_vld),
			.lf_id    (lf_id),
			.lf_lvl   (lf_lvl),
			.lf_runs  (lf_runs),
			.lf_cond  (lf_cond),
			.rt_vld   (rt_vld),
			.rt_id    (rt_id),
			.rt_lvl   (rt_lvl),
			.rt_runs  (rt_runs),
			.vld      (c_vld[i]),
			.id       (c_id[i]),
			.lvl      (c_lvl[i]),
			.runs     (c_runs[i]),
			.cond     (c_cond[i])
		);

		assign vld_vec[i] = c_vld[i];
	end

	assign out_valid = out_valid_q;
	assign running_id = out_id_q;
	assign running_valid = out_rv_q;
	assign switch_total = out_sw_q;
	assign status_code = out_rej_q;

	// The scan always ends in the take step.
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> (state_q == S_SCAN) || (state_q == S_TAKE))
		else $error("scan left for a state other than take");

	// The switch count never goes back.
	a_sw_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (sw_q >= $past(sw_q)))
		else $error("switch count decreased");

	// Outside the rotation the queued entries fill the list from cell 0 with no gap.
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |-> (((vld_vec + NCELL'(1)) & vld_vec) == '0))
		else $error("ready list has a gap");

	// An idle result reports id zero.
	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_rv_q) |-> (out_id_q == '0))
		else $error("idle result with nonzero id");

endmodule

// File: tb/mlfq_sched_checker.sv
// Checker for the thread scheduler: mirrors the scheduler state and compares every result beat.
`timescale 1ns / 1ps
module mlfq_sched_checker
	import mlfq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [2:0]           opcode,
	input  logic [TID_W-1:0]     thread_id,
	input  logic                 has_waiter,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [TID_W-1:0]     running_id,
	input  logic                 running_valid,
	input  logic [SWITCH_W-1:0]  switch_total,
	input  logic                 status_code,
	output int                   errors,
	output int                   pending
);

	localparam int LEVELS = 4;
	localparam int THREADS = 64;

	typedef struct packed {
		logic [TID_W-1:0]    run_id;
		logic                run_on;
		logic [SWITCH_W-1:0] switches;
		logic                rejected;
	} sched_view_t;

	// configuration copy
	logic                policy_mlfq;
	logic [PERIOD_W-1:0] age_period;
	logic [TID_W-1:0]    main_id;

	// scheduler state copy
	logic [TID_W-1:0]    cur_id;
	logic                cur_on;
	thr_state_t          tstate [THREADS];
	logic [1:0]          tlevel [THREADS];
	logic [15:0]         truns [THREADS];
	logic [TID_W-1:0]    ready_q [LEVELS][$];
	logic [PERIOD_W-1:0] phase;
	logic [SWITCH_W-1:0] switches;
	logic                booted;

	sched_view_t views_due [$];

	task automatic count_switch();
		if (switches != '1)
			switches++;
	endtask

	task automatic enqueue(input int lv, input logic [TID_W-1:0] id);
		if (ready_q[lv].size() < THREADS)
			ready_q[lv].push_back(id);
		tlevel[id] = lv[1:0];
	endtask

	task automatic reschedule(input go_kind_t kind);
		int lv, bl, bp;
		logic [TID_W-1:0] id;
		logic found;
		logic [15:0] best;
		found = 0;
		bl = 0;
		bp = 0;
		best = '0;
		count_switch();
		if (cur_on && kind != GO_NONE) begin
			id = cur_id;
			if (truns[id] != 16'hFFFF)
				truns[id]++;
			if (kind == GO_BLOCK) begin
				tstate[id] = ST_BLOCKED;
			end else begin
				tstate[id] = ST_READY;
				lv = 0;
				if (policy_mlfq) begin
					lv = tlevel[id];
					if (kind == GO_PREEMPT && lv + 1 < LEVELS)
						lv++;
				end
				enqueue(lv, id);
			end
		end
		cur_on = 0;
		if (policy_mlfq) begin
			// aging: pull every lower level back to the top, in order
			if (phase == 0)
				for (int l = 1; l < LEVELS; l++)
					while (ready_q[l].size() != 0) begin
						id = ready_q[l].pop_front();
						enqueue(0, id);
					end
			for (int l = 0; l < LEVELS; l++)
				if (!found && ready_q[l].size() != 0) begin
					found = 1;
					bl = l;
					bp = 0;
				end
		end else begin
			for (int l = 0; l < LEVELS; l++)
				for (int p = 0; p < ready_q[l].size(); p++)
					if (!found || truns[ready_q[l][p]] < best) begin
						found = 1;
						best = truns[ready_q[l][p]];
						bl = l;
						bp = p;
					end
		end
		if (found) begin
			id = ready_q[bl][bp];
			ready_q[bl].delete(bp);
			tstate[id] = ST_RUNNING;
			cur_id = id;
			cur_on = 1;
			count_switch();
		end
	endtask

	task automatic make_ready(input logic [TID_W-1:0] id);
		tstate[id] = ST_READY;
		enqueue(0, id);
	endtask

	task automatic apply_event(input logic [2:0] op, input logic [TID_W-1:0] tid,
			input logic waiter);
		logic rej;
		logic [16:0] next_phase, per;
		logic any;
		sched_view_t v;
		rej = 0;
		any = 0;
		case (op)
			OP_CREATE: begin
				if (!booted) begin
					booted = 1;
					tstate[main_id] = ST_RUNNING;
					tlevel[main_id] = 0;
					truns[main_id] = 0;
					cur_id = main_id;
					cur_on = 1;
				end
				if (tstate[tid] == ST_ABSENT) begin
					truns[tid] = 0;
					make_ready(tid);
				end else begin
					rej = 1;
				end
			end
			OP_TICK: begin
				per = (age_period == 0) ? 17'd1 : {1'b0, age_period};
				next_phase = {1'b0, phase} + 17'd1;
				phase = (next_phase >= per) ? '0 : next_phase[PERIOD_W-1:0];
				for (int l = 0; l < LEVELS; l++)
					if (ready_q[l].size() != 0)
						any = 1;
				if (cur_on)
					reschedule(GO_PREEMPT);
				else if (any)
					reschedule(GO_NONE);
			end
			OP_YIELD, OP_BLOCK: begin
				if (!cur_on)
					rej = 1;
				else
					reschedule(op == OP_YIELD ? GO_YIELD : GO_BLOCK);
			end
			OP_EXIT: begin
				if (!cur_on || (waiter && tstate[tid] != ST_BLOCKED)) begin
					rej = 1;
				end else begin
					tstate[cur_id] = ST_ABSENT;
					truns[cur_id] = 0;
					tlevel[cur_id] = 0;
					cur_on = 0;
					if (waiter)
						make_ready(tid);
					reschedule(GO_NONE);
				end
			end
			OP_WAKE: begin
				if (tstate[tid] == ST_BLOCKED)
					make_ready(tid);
				else
					rej = 1;
			end
			default: rej = 1;
		endcase
		v.run_id = cur_on ? cur_id : '0;
		v.run_on = cur_on;
		v.switches = switches;
		v.rejected = rej;
		views_due.push_back(v);
	endtask

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		if (errors < 10)
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		policy_mlfq = 0;
		age_period = 16'd100;
		main_id = '0;
		cur_id = '0;
		cur_on = 0;
		phase = '0;
		switches = '0;
		booted = 0;
		for (int i = 0; i < THREADS; i++) begin
			tstate[i] = ST_ABSENT;
			tlevel[i] = '0;
			truns[i] = '0;
		end
	end

	always @(posedge clk) begin
		sched_view_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_POLICY_MODE)
					policy_mlfq = cfg_data[0];
				else if (cfg_index == CFG_AGING_PERIOD)
					age_period = cfg_data;
				else if (cfg_index == CFG_MAIN_THREAD)
					main_id = cfg_data[TID_W-1:0];
			end
			if (in_valid && !in_stall)
				apply_event(opcode, thread_id, has_waiter);
			if (out_valid && !out_stall) begin
				if (views_due.size() == 0) begin
					report("unexpected beat", 0, 1);
				end else begin
					want = views_due.pop_front();
					if (running_id !== want.run_id)
						report("running_id", want.run_id, running_id);
					if (running_valid !== want.run_on)
						report("running_valid", want.run_on, running_valid);
					if (switch_total !== want.switches)
						report("switch_total", want.switches, switch_total);
					if (status_code !== want.rejected)
						report("status_code", want.rejected, status_code);
				end
			end
			pending = views_due.size();
		end
	end

endmodule

// File: tb/mlfq_psjf_thread_scheduler_top_tb.sv
// Stimulus and verdict for the MLFQ / PSJF thread scheduler.
`timescale 1ns / 1ps
module mlfq_psjf_thread_scheduler_top_tb;
	import mlfq_pkg::*;

	// cycles without any accepted beat before the run is declared hung
	localparam int HANG_LIMIT = 5000;
	localparam int PHASE_ITEMS = 130;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data = '0;
	logic                 in_valid = 0;
	logic                 in_stall;
	logic [2:0]           opcode = '0;
	logic [TID_W-1:0]     thread_id = '0;
	logic                 has_waiter = 0;
	logic                 out_valid;
	logic                 out_stall = 0;
	logic [TID_W-1:0]     running_id;
	logic                 running_valid;
	logic [SWITCH_W-1:0]  switch_total;
	logic                 status_code;

	int errors;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	mlfq_psjf_thread_scheduler_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .thread_id(thread_id), .has_waiter(has_waiter),
		.out_valid(out_valid), .out_stall(out_stall),
		.running_id(running_id), .running_valid(running_valid),
		.switch_total(switch_total), .status_code(status_code)
	);

	mlfq_sched_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .thread_id(thread_id), .has_waiter(has_waiter),
		.out_valid(out_valid), .out_stall(out_stall),
		.running_id(running_id), .running_valid(running_valid),
		.switch_total(switch_total), .status_code(status_code),
		.errors(errors), .pending(pending)
	);

	// Receiver side: stall at random, independent of valid.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Watchdog: reset the count on any accepted beat, otherwise advance it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("mlfq_psjf_thread_scheduler_top_tb: errors");
				$finish;
			end
		end
	end

	// Write one register, then drop the enable; the caller is at a rising edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	// Offer one event beat, with random idle cycles ahead of it, and hold it until taken.
	task automatic send_event(input logic [2:0] op, input logic [TID_W-1:0] tid,
			input logic waiter);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		thread_id <= tid;
		has_waiter <= waiter;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid, drain every result, then give the block time to go idle.
	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Random event, biased toward a small pool of ids so blocks, wakes and exits meet.
	task automatic random_event();
		int pick;
		logic [2:0] op;
		logic [TID_W-1:0] tid;
		pick = $urandom_range(99);
		if (pick < 18)      op = OP_CREATE;
		else if (pick < 46) op = OP_TICK;
		else if (pick < 58) op = OP_YIELD;
		else if (pick < 70) op = OP_BLOCK;
		else if (pick < 82) op = OP_EXIT;
		else if (pick < 97) op = OP_WAKE;
		else                op = 3'($urandom_range(7, 6));
		tid = ($urandom_range(99) < 70) ? TID_W'($urandom_range(11)) : TID_W'($urandom);
		send_event(op, tid, 1'($urandom));
	endtask

	task automatic run_phase(input logic mode, input logic [PERIOD_W-1:0] period,
			input int idle, input int stall);
		write_reg(CFG_POLICY_MODE, {15'd0, mode});
		write_reg(CFG_AGING_PERIOD, period);
		write_reg(CFG_MAIN_THREAD, PERIOD_W'($urandom_range(63)));
		idle_pct = idle;
		stall_pct = stall;
		repeat (PHASE_ITEMS) random_event();
		settle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part in PSJF with the highest main id.
		write_reg(CFG_POLICY_MODE, '0);
		write_reg(CFG_AGING_PERIOD, 16'd2);
		write_reg(CFG_MAIN_THREAD, 16'd63);
		send_event(OP_CREATE, 6'd0, 0);   // installs main thread, queues 0
		send_event(OP_CREATE, 6'd63, 1);  // main already live: reject
		send_event(OP_CREATE, 6'd1, 0);
		send_event(OP_CREATE, 6'd0, 0);   // duplicate: reject
		send_event(OP_TICK, 6'd0, 0);
		send_event(OP_YIELD, 6'd0, 0);
		send_event(OP_BLOCK, 6'd0, 0);
		send_event(OP_WAKE, 6'd2, 0);     // never created: reject
		send_event(OP_WAKE, 6'd63, 0);
		send_event(OP_WAKE, 6'd0, 0);
		send_event(OP_BLOCK, 6'd0, 0);
		send_event(OP_EXIT, 6'd5, 1);     // waiter not blocked: reject
		send_event(OP_EXIT, 6'd1, 1);
		send_event(OP_EXIT, 6'd0, 1);
		send_event(OP_EXIT, 6'd0, 0);
		send_event(OP_EXIT, 6'd0, 0);
		send_event(OP_EXIT, 6'd0, 0);
		send_event(OP_YIELD, 6'd0, 0);    // idle: reject
		send_event(OP_BLOCK, 6'd63, 1);
		send_event(OP_EXIT, 6'd63, 0);
		send_event(OP_TICK, 6'd0, 0);     // idle and nothing ready
		send_event(3'd6, 6'd0, 0);
		send_event(3'd7, 6'd63, 1);
		send_event(OP_CREATE, 6'd62, 0);
		send_event(OP_TICK, 6'd0, 0);     // idle with a ready thread
		settle();

		// Random phases across both policies and the period extremes.
		run_phase(1'b1, 16'd1, 0, 0);
		run_phase(1'b1, 16'hFFFF, 79, 0);
		run_phase(1'b0, 16'd3, 0, 79);
		run_phase(1'b1, 16'd0, 15, 15);
		run_phase(1'b1, 16'd5, 0, 0);

		if (errors == 0 && pending == 0)
			$display("mlfq_psjf_thread_scheduler_top_tb: clean");
		else
			$display("mlfq_psjf_thread_scheduler_top_tb: errors");
		$finish;
	end

endmodule
